FILE: hdl/fdi_pkg.sv
// ----------------------------------------------------------------------------
// fdi_pkg
// Shared constants, types and fixed-point helpers for the field delta
// indicator: widths, reciprocal constants and register map.
// ----------------------------------------------------------------------------
package fdi_pkg;

  // Sizing
  localparam int WinLen     = 5;
  localparam int CalibLen   = 100;
  localparam int SampleBits = 10;
  localparam int FracBits   = 24;
  localparam int QW         = FracBits + 1;  // Q0.24 including 1.0
  localparam int Shift      = FracBits - SampleBits;

  localparam int SumW  = $clog2(WinLen * ((1 << SampleBits) - 1) + 1);
  localparam int CalW  = $clog2(CalibLen * ((1 << SampleBits) - 1) + 1);
  localparam int CntW  = $clog2(CalibLen + 2);
  localparam int SlotW = (WinLen > 1) ? $clog2(WinLen) : 1;

  // Division by a constant: floor(x / C) = (x * K) >> N with
  // N = bits(x) + ceil(log2 C) and K = ceil(2^N / C).
  localparam int MeanXW = SumW + Shift;
  localparam int MeanN  = MeanXW + $clog2(WinLen);
  localparam longint unsigned MeanK =
    ((64'd1 << MeanN) + 64'(WinLen) - 64'd1) / 64'(WinLen);
  localparam int MeanKW = $clog2(MeanK + 64'd1);
  localparam int MeanPW = MeanXW + MeanKW;

  localparam int CalXW = CalW + Shift;
  localparam int CalN  = CalXW + $clog2(CalibLen);
  localparam longint unsigned CalK =
    ((64'd1 << CalN) + 64'(CalibLen) - 64'd1) / 64'(CalibLen);
  localparam int CalKW = $clog2(CalK + 64'd1);
  localparam int CalPW = CalXW + CalKW;

  // Q0.24 landmarks
  localparam logic [QW-1:0] QOne  = QW'(1) << FracBits;
  localparam logic [QW-1:0] QHalf = QW'(1) << (FracBits - 1);

  // Colour thresholds on 5*delta
  localparam int D5W = QW + 3;
  localparam logic [D5W-1:0] TwoOne   = D5W'(2) << FracBits;
  localparam logic [D5W-1:0] ThreeOne = D5W'(3) << FracBits;

  // LED power arithmetic, all exact on integers
  localparam int PW = 36;
  localparam logic [PW-1:0] NeutLoOfs = PW'(390);                    // 400 - 10
  localparam logic [PW-1:0] NeutHiNum = PW'(600) << FracBits;
  localparam logic [PW-1:0] BelowNum  = PW'((64'd512 << FracBits) / 64'd5);
  localparam logic [PW-1:0] AboveNum  = PW'(((64'd768 << FracBits) + 64'd4) / 64'd5);
  localparam logic [PW-1:0] PowerBase = PW'(10);

  // Register map
  localparam int AddrW = 4;
  localparam logic [1:0] RegDriftStep = 2'd0;
  localparam logic [1:0] RegBaseFloor = 2'd1;
  localparam logic [1:0] RegBaseCeil  = 2'd2;

  localparam logic [15:0]   DriftStepRst = 16'd168;
  localparam logic [QW-1:0] BaseFloorRst = QW'(1677722);
  localparam logic [QW-1:0] BaseCeilRst  = QW'(15099494);

  typedef enum logic [1:0] {
    ColNeutral = 2'd0,
    ColBelow   = 2'd1,
    ColAbove   = 2'd2
  } colour_e;

  typedef struct packed {
    logic [15:0]   drift_step;
    logic [QW-1:0] base_floor;
    logic [QW-1:0] base_ceil;
  } cfg_t;

endpackage

FILE: hdl/fdi_cfg.sv
// ----------------------------------------------------------------------------
// fdi_cfg
// APB-style register file: drift step, baseline floor and baseline ceiling.
// ----------------------------------------------------------------------------
module fdi_cfg import fdi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drift_step <= DriftStepRst;
      cfg_q.base_floor <= BaseFloorRst;
      cfg_q.base_ceil  <= BaseCeilRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegDriftStep: cfg_q.drift_step <= pwdata[15:0];
        RegBaseFloor: cfg_q.base_floor <= pwdata[QW-1:0];
        RegBaseCeil:  cfg_q.base_ceil  <= pwdata[QW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      RegDriftStep: prdata = {16'd0, cfg_q.drift_step};
      RegBaseFloor: prdata = 32'(cfg_q.base_floor);
      RegBaseCeil:  prdata = 32'(cfg_q.base_ceil);
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/field_delta_indicator.sv
// ----------------------------------------------------------------------------
// field_delta_indicator
// Sensor sample to bar level, colour class, LED power and delta, with a
// calibrated, slowly drifting baseline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one sample per beat (in_valid_i / in_ready_o, sample_i).
//   Output channel: one result beat per sample (out_valid_o / out_ready_i)
//   carrying bar_level_o, colour_o, led_power_o, delta_o and calibrating_o.
//   Configuration: APB-style port, registers at 0x0 drift step, 0x4 baseline
//   floor, 0x8 baseline ceiling; write only while the block is idle.
//   Pipeline: four register stages, each with its own valid bit; out_valid_o
//   is the valid bit of the last stage.
//   Throughput: one sample per cycle unless out_ready_i stalls a full pipe.
//   Stages: window/calibration sums, constant-reciprocal means, delta and
//   baseline drift (the baseline loop closes inside one stage), then output
//   formatting into the result register.
//   Reset clears the window, sample count, calibration sum and baseline and
//   loads the register reset values; no clearing pass is needed.
//   When the receiver stalls, the result register holds and earlier stages
//   keep filling; in_ready_o drops only once every stage holds a sample.
//   calibrating_o is high for the first CalibLen samples.
// ----------------------------------------------------------------------------
module field_delta_indicator import fdi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] sample_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            bar_level_o,
  output logic [1:0]            colour_o,
  output logic [7:0]            led_power_o,
  output logic [QW-1:0]         delta_o,
  output logic                  calibrating_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;

  fdi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic en2, en3, en4, in_fire;

  assign en4        = ~v4_q | out_ready_i;
  assign en3        = ~v3_q | en4;
  assign en2        = ~v2_q | en3;
  assign in_ready_o = ~v1_q | en2;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (en2)        v2_q <= v1_q;
      if (en3)        v3_q <= v2_q;
      if (en4)        v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: moving window, sample count, calibration sum
  // --------------------------------------------------------------------------
  logic [SampleBits-1:0] win_q [WinLen];
  logic [SlotW-1:0]      slot_q;
  logic [SumW-1:0]       win_sum_q, win_sum_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CalW-1:0]       cal_sum_q, cal_sum_d;
  logic                  calib_d, cal_now_d;

  logic [SumW-1:0] p1_sum_q;
  logic [CalW-1:0] p1_cal_sum_q;
  logic            p1_cal_now_q, p1_calib_q;

  always_comb begin
    win_sum_d = win_sum_q - SumW'(win_q[slot_q]) + SumW'(sample_i);
    cnt_d     = (cnt_q < CntW'(CalibLen + 1)) ? cnt_q + CntW'(1) : cnt_q;
    calib_d   = (cnt_d <= CntW'(CalibLen));
    cal_now_d = (cnt_d == CntW'(CalibLen));
    cal_sum_d = calib_d ? cal_sum_q + CalW'(sample_i) : cal_sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinLen; k++) win_q[k] <= '0;
      slot_q    <= '0;
      win_sum_q <= '0;
      cnt_q     <= '0;
      cal_sum_q <= '0;
    end else if (in_fire) begin
      win_q[slot_q] <= sample_i;
      slot_q        <= (slot_q == SlotW'(WinLen - 1)) ? '0 : slot_q + SlotW'(1);
      win_sum_q     <= win_sum_d;
      cnt_q         <= cnt_d;
      cal_sum_q     <= cal_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_sum_q     <= win_sum_d;
      p1_cal_sum_q <= cal_sum_d;
      p1_cal_now_q <= cal_now_d;
      p1_calib_q   <= calib_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: short mean and calibration mean via reciprocal multiply
  // --------------------------------------------------------------------------
  logic [MeanPW-1:0] mean_prod;
  logic [CalPW-1:0]  cal_prod;
  logic [QW-1:0]     p2_mean_q, p2_cal_base_q;
  logic              p2_cal_now_q, p2_calib_q;

  assign mean_prod = MeanPW'({p1_sum_q, Shift'(0)}) * MeanPW'(MeanK);
  assign cal_prod  = CalPW'({p1_cal_sum_q, Shift'(0)}) * CalPW'(CalK);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      p2_mean_q     <= QW'(mean_prod >> MeanN);
      p2_cal_base_q <= QW'(cal_prod >> CalN);
      p2_cal_now_q  <= p1_cal_now_q;
      p2_calib_q    <= p1_calib_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamped delta and baseline drift
  // --------------------------------------------------------------------------
  logic [QW-1:0]        base_q, base_eff, base_d, d_val;
  logic signed [QW+1:0] dl;
  logic [QW:0]          base_up;
  logic [QW-1:0]        p3_mean_q, p3_d_q;
  logic                 p3_calib_q;

  always_comb begin
    base_eff = p2_cal_now_q ? p2_cal_base_q : base_q;
    dl = $signed({2'b00, p2_mean_q}) - $signed({2'b00, base_eff})
       + $signed({2'b00, QHalf});
    if (dl < 0)                                d_val = '0;
    else if (dl > $signed({2'b00, QOne}))      d_val = QOne;
    else                                       d_val = dl[QW-1:0];

    base_up = {1'b0, base_eff} + (QW+1)'(cfg.drift_step);
    base_d  = base_eff;
    if (d_val < QHalf) begin
      if (base_eff > cfg.base_floor) begin
        base_d = (base_eff >= QW'(cfg.drift_step)) ? base_eff - QW'(cfg.drift_step) : '0;
      end
    end else begin
      if (base_eff < cfg.base_ceil) begin
        base_d = (base_up > {1'b0, QOne}) ? QOne : base_up[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (en3 && v2_q) begin
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      p3_mean_q  <= p2_mean_q;
      p3_d_q     <= d_val;
      p3_calib_q <= p2_calib_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: bar level, colour class, LED power into the result register
  // --------------------------------------------------------------------------
  logic [QW+3:0]  mean9;
  logic [D5W-1:0] d5;
  logic [PW-1:0]  d1000, d256, pwr;
  colour_e        col;

  logic [3:0]    bar_q;
  colour_e       col_q;
  logic [7:0]    pwr_q;
  logic [QW-1:0] delta_q;
  logic          calib_q;

  always_comb begin
    mean9 = (QW+4)'(p3_mean_q) * (QW+4)'(9);
    d5    = D5W'(p3_d_q) + {p3_d_q, 2'b00};
    d1000 = PW'(p3_d_q) * PW'(1000);
    d256  = PW'({p3_d_q, 8'd0});
    if (d5 > TwoOne && d5 < ThreeOne) begin
      col = ColNeutral;
      if (p3_d_q < QHalf) pwr = (d1000 >> FracBits) - NeutLoOfs;
      else                pwr = ((NeutHiNum - d1000) >> FracBits) + PowerBase;
    end else if (d5 <= TwoOne) begin
      col = ColBelow;
      pwr = ((BelowNum - d256) >> FracBits) + PowerBase;
    end else begin
      col = ColAbove;
      pwr = ((d256 - AboveNum) >> FracBits) + PowerBase;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      bar_q   <= 4'(mean9 >> FracBits);
      col_q   <= col;
      pwr_q   <= pwr[7:0];
      delta_q <= p3_d_q;
      calib_q <= p3_calib_q;
    end
  end

  assign out_valid_o   = v4_q;
  assign bar_level_o   = bar_q;
  assign colour_o      = col_q;
  assign led_power_o   = pwr_q;
  assign delta_o       = delta_q;
  assign calibrating_o = calib_q;

endmodule
